// ===== rtl/lpr_pkg.sv =====
`default_nettype none

package lpr_pkg;

  // Default table size and page width
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // Configuration register: frames the table may fill and replace among
  localparam int               CFG_W     = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Running totals
  localparam int               COUNT_W   = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Control states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/lpr_cell.sv =====
`default_nettype none

module lpr_cell #(
  parameter int  FRAMES    = 8,
  parameter int  PAGE_BITS = 16,
  parameter int  IDX       = 0,
  parameter type lookup_t  = logic,
  parameter type update_t  = logic,
  parameter type carry_t   = logic
) (
  input  logic    clk,
  input  logic    rst,
  input  lookup_t lookup,
  input  update_t update,
  input  carry_t  carry_in,
  output carry_t  carry_out
);

  localparam int FB    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam logic [FB-1:0]    IDX_F = IDX[FB-1:0];
  localparam logic [CNT_W-1:0] IDX_C = IDX[CNT_W-1:0];

  logic [PAGE_BITS-1:0] page;
  logic [FB-1:0]        rank;
  logic                 match;
  logic                 covered;
  logic                 take_vic;
  carry_t               carry_next;

  // Compare against the searched page and bid for victim
  assign match    = (IDX_C < lookup.look) && (page == lookup.page);
  assign covered  = IDX_C < lookup.active;
  assign take_vic = covered && ((IDX == 0) || (rank > carry_in.vic_rank));

  always_comb begin
    carry_next = carry_in;
    if (!carry_in.found && match) begin
      carry_next.found    = 1'b1;
      carry_next.hit_idx  = IDX_F;
      carry_next.hit_rank = rank;
    end
    if (take_vic) begin
      carry_next.vic_idx  = IDX_F;
      carry_next.vic_rank = rank;
      carry_next.vic_page = page;
    end
  end

  // Hand the search token to the next cell
  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

  // Apply the broadcast update: chosen frame goes most recent, newer ones age
  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= '0;
    end else if (update.en) begin
      if (update.frame == IDX_F) begin
        rank <= '0;
      end else if ((IDX_C < update.filled) && (rank < update.old_rank)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  // Store the new page in the chosen frame
  always_ff @(posedge clk) begin
    if (update.en && update.write && (update.frame == IDX_F)) begin
      page <= lookup.page;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+---------------------------
// item in  | page                                          | taken when start && !busy
// result   | hit frame evicted evicted_page hit_count      | valid while done is high
//          | fault_count                                   |
// config   | cfg_wr_data                                   | written when cfg_wr_en
//
// For each reference the search token walks the row of frame cells one cell
// per cycle, then the update state moves ranks and pages. A new item is taken
// in the cycle that done is shown. Synchronous reset empties the table, clears
// ranks and totals and loads the frame count with 8. The done strobe is high for
// a single cycle; the result cannot be stalled.
`default_nettype none

module lru_page_replacement #(
  parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [PAGE_BITS-1:0]                 page,
  input  logic                                 cfg_wr_en,
  input  logic [lpr_pkg::CFG_W-1:0]            cfg_wr_data,
  output logic                                 done,
  output logic                                 hit,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame,
  output logic                                 evicted,
  output logic [PAGE_BITS-1:0]                 evicted_page,
  output logic [lpr_pkg::COUNT_W-1:0]          hit_count,
  output logic [lpr_pkg::COUNT_W-1:0]          fault_count
);

  import lpr_pkg::*;

  localparam int FB    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [NW-1:0]    FRAMES_N  = NW'(FRAMES);
  localparam logic [CNT_W-1:0] FRAMES_C  = CNT_W'(FRAMES);
  localparam logic [FB-1:0]    LAST_STEP = FB'(FRAMES - 1);

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     look;
    logic [CNT_W-1:0]     active;
  } lookup_t;

  typedef struct packed {
    logic             en;
    logic             write;
    logic [FB-1:0]    frame;
    logic [FB-1:0]    old_rank;
    logic [CNT_W-1:0] filled;
  } update_t;

  typedef struct packed {
    logic                 found;
    logic [FB-1:0]        hit_idx;
    logic [FB-1:0]        hit_rank;
    logic [FB-1:0]        vic_idx;
    logic [FB-1:0]        vic_rank;
    logic [PAGE_BITS-1:0] vic_page;
  } carry_t;

  state_t               state;
  state_t               state_next;
  logic [CFG_W-1:0]     frames_in_use;
  logic [FB-1:0]        step;
  logic [PAGE_BITS-1:0] page_q;
  logic [CNT_W-1:0]     filled;
  logic [COUNT_W-1:0]   hit_total;
  logic [COUNT_W-1:0]   fault_total;
  logic [NW-1:0]        cfg_ext;
  logic [CNT_W-1:0]     active;
  logic                 room;
  logic                 accept;
  lookup_t              lookup;
  update_t              update;
  carry_t               chain [FRAMES+1];
  carry_t               tail;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Clamp the frame count into 1 .. FRAMES
  assign cfg_ext = NW'(frames_in_use);
  always_comb begin
    priority if (cfg_ext == '0) begin
      active = CNT_W'(1);
    end else if (cfg_ext > FRAMES_N) begin
      active = FRAMES_C;
    end else begin
      active = CNT_W'(cfg_ext);
    end
  end

  assign room          = filled < active;
  assign lookup.page   = page_q;
  assign lookup.active = active;
  assign lookup.look   = room ? filled : active;

  // Seed the search token at the head of the row
  assign chain[0] = '{found: 1'b0, hit_idx: '0, hit_rank: '0,
                      vic_idx: '0, vic_rank: '0, vic_page: '0};

  // Row of frame cells
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lpr_cell #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .IDX       (i),
      .lookup_t  (lookup_t),
      .update_t  (update_t),
      .carry_t   (carry_t)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .lookup    (lookup),
      .update    (update),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1])
    );
  end

  assign tail = chain[FRAMES];

  // Pick the frame to touch: hit frame, next empty frame, or the LRU victim
  always_comb begin
    update.en     = (state == ST_UPDATE);
    update.filled = filled;
    priority if (tail.found) begin
      update.write    = 1'b0;
      update.frame    = tail.hit_idx;
      update.old_rank = tail.hit_rank;
    end else if (room) begin
      update.write    = 1'b1;
      update.frame    = FB'(filled);
      update.old_rank = FB'(filled);
    end else begin
      update.write    = 1'b1;
      update.frame    = tail.vic_idx;
      update.old_rank = tail.vic_rank;
    end
  end

  // Advance the control sequence
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (step == LAST_STEP) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SEARCH) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

  // Hold the referenced page for the whole search
  always_ff @(posedge clk) begin
    if (accept) begin
      page_q <= page;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  // Fill count and saturating totals
  always_ff @(posedge clk) begin
    if (rst) begin
      filled      <= '0;
      hit_total   <= '0;
      fault_total <= '0;
    end else if (state == ST_UPDATE) begin
      if (tail.found) begin
        if (hit_total != COUNT_MAX) hit_total <= hit_total + 1'b1;
      end else begin
        if (fault_total != COUNT_MAX) fault_total <= fault_total + 1'b1;
        if (room) filled <= filled + 1'b1;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_UPDATE);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      hit          <= tail.found;
      frame        <= update.frame;
      evicted      <= !tail.found && !room;
      evicted_page <= (!tail.found && !room) ? tail.vic_page : '0;
    end
  end

  assign hit_count   = hit_total;
  assign fault_count = fault_total;

  // A result follows only from the update cycle
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("result strobe without an update cycle");

  // The block stays busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("item taken but block not busy");

  // The fill count never passes the table size
  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= FRAMES_C)
    else $error("fill count beyond table size");

  // A hit leaves the fault total alone and never evicts
  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> ($stable(fault_count) && !evicted))
    else $error("hit changed fault total or evicted");

  // Eviction only when the covered frames are all filled
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && !tail.found && !room) |-> (filled >= active))
    else $error("eviction with an empty frame left");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  import lpr_pkg::*;

  localparam int NUM_FRAMES  = FRAMES_DEF;
  localparam int PAGE_W      = PAGE_BITS_DEF;
  localparam int FRAME_W     = 3;
  localparam int REF_LATENCY = NUM_FRAMES + 2;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic                 hit;
    logic [FRAME_W-1:0]   frame;
    logic                 evicted;
    logic [PAGE_W-1:0]    evicted_page;
    logic [COUNT_W-1:0]   hit_count;
    logic [COUNT_W-1:0]   fault_count;
  } outcome_t;

  // Frame table predictor plus the queue of outcomes still to arrive
  class frame_table_board;
    logic [PAGE_W-1:0]  slot_page [NUM_FRAMES];
    logic [2:0]         slot_rank [NUM_FRAMES];
    int                 filled;
    logic [CFG_W-1:0]   frame_count;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
    outcome_t           pending_q[$];
    int                 mismatches;
    int                 checked;
    int                 seen_hits;
    int                 seen_evictions;

    function new();
      for (int i = 0; i < NUM_FRAMES; i++) begin
        slot_page[i] = '0;
        slot_rank[i] = '0;
      end
      filled         = 0;
      frame_count    = CFG_RESET;
      hits           = '0;
      faults         = '0;
      mismatches     = 0;
      checked        = 0;
      seen_hits      = 0;
      seen_evictions = 0;
    endfunction

    function void write_count(logic [CFG_W-1:0] v);
      frame_count = v;
    endfunction

    // Clamp the register into 1 .. NUM_FRAMES
    function int covered();
      int n;
      n = int'(frame_count);
      if (n < 1) n = 1;
      if (n > NUM_FRAMES) n = NUM_FRAMES;
      return n;
    endfunction

    // Make frame f most recent; age every filled frame that was newer
    function void promote(int f);
      logic [2:0] old;
      old = slot_rank[f];
      for (int i = 0; i < filled && i < NUM_FRAMES; i++)
        if (i != f && slot_rank[i] < old) slot_rank[i]++;
      slot_rank[f] = '0;
    endfunction

    // Work out the outcome of one accepted page reference
    function void note_ref(logic [PAGE_W-1:0] pg);
      outcome_t o;
      int       n;
      int       look;
      int       best;
      bit       found;
      o     = '0;
      found = 0;
      n     = covered();
      look  = (filled < n) ? filled : n;
      // lowest matching frame wins
      for (int i = 0; i < look; i++)
        if (!found && slot_page[i] == pg) begin
          found   = 1;
          o.frame = FRAME_W'(i);
        end
      if (found) begin
        o.hit = 1'b1;
        promote(int'(o.frame));
        if (hits != COUNT_MAX) hits++;
      end else begin
        if (faults != COUNT_MAX) faults++;
        if (filled < n) begin
          // fill the next empty frame
          o.frame = FRAME_W'(filled);
          for (int i = 0; i < filled; i++) slot_rank[i]++;
          slot_page[filled] = pg;
          slot_rank[filled] = '0;
          filled++;
        end else begin
          // replace the oldest covered frame
          best = 0;
          for (int i = 1; i < n; i++)
            if (slot_rank[i] > slot_rank[best]) best = i;
          o.frame         = FRAME_W'(best);
          o.evicted       = 1'b1;
          o.evicted_page  = slot_page[best];
          slot_page[best] = pg;
          promote(best);
        end
      end
      o.hit_count   = hits;
      o.fault_count = faults;
      pending_q.push_back(o);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t MISMATCH: %s", $time, msg);
    endfunction

    // Compare one outcome from the block with the oldest prediction
    function void check_result(outcome_t got);
      outcome_t exp;
      if (pending_q.size() == 0) begin
        report($sformatf("outcome with nothing pending: hit=%0b frame=%0d", got.hit, got.frame));
        return;
      end
      exp = pending_q.pop_front();
      checked++;
      if (got.hit === 1'b1) seen_hits++;
      if (got.evicted === 1'b1) seen_evictions++;
      if (got !== exp)
        report($sformatf({"exp hit=%0b frame=%0d ev=%0b ev_page=%h hits=%0d faults=%0d, ",
                          "got hit=%0b frame=%0d ev=%0b ev_page=%h hits=%0d faults=%0d"},
                         exp.hit, exp.frame, exp.evicted, exp.evicted_page, exp.hit_count,
                         exp.fault_count, got.hit, got.frame, got.evicted, got.evicted_page,
                         got.hit_count, got.fault_count));
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [PAGE_W-1:0]   page;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;
  logic                done;
  logic                hit;
  logic [FRAME_W-1:0]  frame;
  logic                evicted;
  logic [PAGE_W-1:0]   evicted_page;
  logic [COUNT_W-1:0]  hit_count;
  logic [COUNT_W-1:0]  fault_count;

  frame_table_board board = new();
  int               idle_cycles;
  int               issued;
  int               settings_used;

  lru_page_replacement uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .page        (page),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .hit         (hit),
    .frame       (frame),
    .evicted     (evicted),
    .evicted_page(evicted_page),
    .hit_count   (hit_count),
    .fault_count (fault_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Track accepted items, register writes and outcomes at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) board.write_count(cfg_wr_data);
      if (start && !busy) board.note_ref(page);
      if (done)
        board.check_result({hit, frame, evicted, evicted_page, hit_count, fault_count});
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item or outcome for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones; none at all in burst phases
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one reference and hold it until taken; drop start only if a gap follows
  task automatic issue_ref(input logic [PAGE_W-1:0] pg, input int gap);
    start <= 1'b1;
    page  <= pg;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write the frame count once every outstanding outcome has come back
  task automatic set_frame_count(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0 || busy) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [PAGE_W-1:0] pool [16];
    logic [CFG_W-1:0]  setting [NUM_PHASES];
    int                pool_size;
    int                r;
    bit                burst;
    logic [PAGE_W-1:0] pg;

    rst         <= 1'b1;
    start       <= 1'b0;
    page        <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    issued        = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Fill all frames from empty, with extreme and alternating pages
    set_frame_count(4'd8);
    issue_ref(16'h0000, 0);
    issue_ref(16'hFFFF, 1);
    issue_ref(16'h0001, 0);
    issue_ref(16'h8000, 3);
    issue_ref(16'h5555, 0);
    issue_ref(16'hAAAA, 0);
    issue_ref(16'h0002, 2);
    issue_ref(16'h0003, 0);
    // Hits, then a miss that replaces the oldest frame
    issue_ref(16'h0000, 0);
    issue_ref(16'hFFFF, 5);
    issue_ref(16'h0004, 0);
    // Lower the count: pages in upper frames go unseen and get duplicated below
    set_frame_count(4'd2);
    issue_ref(16'h5555, 0);
    issue_ref(16'h5555, 1);
    issue_ref(16'hAAAA, 0);
    // Zero acts as a single frame
    set_frame_count(4'd0);
    issue_ref(16'h1234, 0);
    issue_ref(16'h1234, 0);
    issue_ref(16'h0003, 0);
    // Values above the table size act as the full table; duplicates resolve low
    set_frame_count(4'd15);
    issue_ref(16'h5555, 0);
    issue_ref(16'hAAAA, 2);
    issue_ref(16'h0003, 0);
    issue_ref(16'h1234, 0);
    issue_ref(16'h8000, 0);

    // Random phases, each with its own frame count and working set
    setting[0] = 4'd1;
    setting[1] = 4'd8;
    setting[2] = 4'd3;
    setting[3] = 4'd0;
    setting[4] = 4'd15;
    setting[5] = 4'd6;
    setting[6] = 4'($urandom_range(0, 15));
    setting[7] = 4'($urandom_range(0, 15));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_frame_count(setting[ph]);
      pool_size = $urandom_range(1, 12);
      for (int i = 0; i < pool_size; i++) pool[i] = 16'($urandom_range(0, 65535));
      burst = (ph % 3 == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80)      pg = pool[$urandom_range(0, pool_size - 1)];
        else if (r < 95) pg = 16'($urandom_range(0, 65535));
        else             pg = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        issue_ref(pg, pick_gap(burst));
      end
    end

    // Drain and let the block settle
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (REF_LATENCY + 4) @(posedge clk);

    $display("Run: %0d references under %0d frame-count settings (0, 1, 8, 15 included)",
             issued, settings_used);
    $display("Checked %0d outcomes: %0d hits, %0d evictions, %0d mismatches",
             board.checked, board.seen_hits, board.seen_evictions, board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
